### design/knps_pkg.sv
`default_nettype none

package knps_pkg;

  localparam int MAX_KEPT  = 8;
  localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W     = $clog2(MAX_KEPT + 1);
  localparam int COORD_W   = 16;
  localparam int MAG_W     = 16;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SQ_W      = PROD_W + 1;
  localparam int ROOT_W    = 17;
  localparam int RANK_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REF_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y = CFG_IDX_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [ROOT_W-1:0]         root_t;

  // start / completion pair for the shared arithmetic units
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

### design/knps_sqdist.sv
`default_nettype none

module knps_sqdist (
  input  wire                 clk,
  input  wire                 rst,
  input  knps_pkg::unit_req_t req,
  input  knps_pkg::coord_t    px,
  input  knps_pkg::coord_t    py,
  input  knps_pkg::coord_t    rx,
  input  knps_pkg::coord_t    ry,
  output knps_pkg::unit_stat_t stat,
  output knps_pkg::sq_t       sq
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SQX  = 2'd1;
  localparam logic [1:0] PH_SQY  = 2'd2;
  localparam logic [1:0] PH_ADD  = 2'd3;

  logic [1:0]                    ph;
  logic [1:0]                    ph_next;
  logic [knps_pkg::MAG_W-1:0]    dx;
  logic [knps_pkg::MAG_W-1:0]    dy;
  logic [knps_pkg::PROD_W-1:0]   prod;
  logic                          done;
  logic [knps_pkg::COORD_W:0]    diff_x;
  logic [knps_pkg::COORD_W:0]    diff_y;
  logic [knps_pkg::MAG_W-1:0]    mag_x;
  logic [knps_pkg::MAG_W-1:0]    mag_y;
  logic [knps_pkg::MAG_W-1:0]    mul_op;
  logic [knps_pkg::PROD_W-1:0]   mul_res;

  // magnitude of a 17-bit difference always fits in 16 bits
  always_comb begin
    diff_x = {px[knps_pkg::COORD_W-1], px} - {rx[knps_pkg::COORD_W-1], rx};
    diff_y = {py[knps_pkg::COORD_W-1], py} - {ry[knps_pkg::COORD_W-1], ry};
    mag_x  = diff_x[knps_pkg::COORD_W] ? knps_pkg::MAG_W'(-diff_x) : diff_x[knps_pkg::MAG_W-1:0];
    mag_y  = diff_y[knps_pkg::COORD_W] ? knps_pkg::MAG_W'(-diff_y) : diff_y[knps_pkg::MAG_W-1:0];
  end

  // the one multiplier, squaring dx then dy
  always_comb begin
    mul_op  = (ph == PH_SQX) ? dx : dy;
    mul_res = knps_pkg::PROD_W'(mul_op) * knps_pkg::PROD_W'(mul_op);
  end

  always_comb begin
    ph_next = ph;
    unique case (ph)
      PH_IDLE: if (req.start) ph_next = PH_SQX;
      PH_SQX:  ph_next = PH_SQY;
      PH_SQY:  ph_next = PH_ADD;
      PH_ADD:  ph_next = PH_IDLE;
      default: ph_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      ph   <= ph_next;
      done <= (ph == PH_ADD);
    end
  end

  always_ff @(posedge clk) begin
    if (ph == PH_IDLE && req.start) begin
      dx <= mag_x;
      dy <= mag_y;
    end
    if (ph == PH_SQX || ph == PH_SQY) begin
      prod <= mul_res;
    end
    if (ph == PH_SQY) begin
      sq <= knps_pkg::SQ_W'(prod);
    end else if (ph == PH_ADD) begin
      sq <= sq + knps_pkg::SQ_W'(prod);
    end
  end

  assign stat.busy = (ph != PH_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

### design/knps_sqrt.sv
`default_nettype none

module knps_sqrt (
  input  wire                  clk,
  input  wire                  rst,
  input  knps_pkg::unit_req_t  req,
  input  knps_pkg::sq_t        radicand,
  output knps_pkg::unit_stat_t stat,
  output knps_pkg::root_t      root_out
);

  localparam int RAD_W = 2 * knps_pkg::ROOT_W;
  localparam int REM_W = knps_pkg::ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int IT_W  = $clog2(knps_pkg::ROOT_W);

  logic [RAD_W-1:0]            rad;
  logic [REM_W-1:0]            rem;
  logic [knps_pkg::ROOT_W-1:0] root;
  logic [IT_W-1:0]             it;
  logic                        busy;
  logic                        fin;
  logic                        done;
  logic [SH_W-1:0]             sh;
  logic [SH_W-1:0]             trial;
  logic [SH_W-1:0]             sub;
  logic                        ge;

  // one root bit per cycle, restoring form
  always_comb begin
    sh    = {rem, rad[RAD_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    sub   = sh - trial;
    ge    = (sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (it == IT_W'(knps_pkg::ROOT_W - 1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && it == IT_W'(knps_pkg::ROOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
      it   <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? sub[REM_W-1:0] : sh[REM_W-1:0];
      root <= {root[knps_pkg::ROOT_W-2:0], ge};
      it   <= it + IT_W'(1);
    end
    // remainder above the root means the true root is past the half
    if (fin) begin
      root_out <= (rem > REM_W'(root)) ? root + knps_pkg::ROOT_W'(1) : root;
    end
  end

  assign stat.busy = busy || fin;
  assign stat.done = done;

endmodule

`default_nettype wire

### design/k_nearest_point_selector.sv
// k-nearest point selector
// Input channel (in_valid / in_stall): one candidate point per request with
// alive and end_of_set flags. in_stall is high whenever an item is in work;
// one item is taken at a time.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 sets
// ref_x, index 1 sets ref_y, other indexes are ignored. cfg_ready is always
// high; write only while the block is idle.
// Output channel (out_valid / out_stall): results of a set, nearest first,
// last_of_run on the final one. An empty set gives one result with found=0.
// Flow: a dead item without end mark is dropped when it is taken. A live item
// goes through the squared-distance unit (one multiplier, dx*dx then dy*dy)
// and then walks the sorted list from the tail, one entry a cycle.
// On end_of_set each result reaches the output register from its bit-serial
// square root; after a live end item the first root waits for the insert;
// the next root starts when the shown result is taken.
// A stalled result holds in the output register; nothing else moves until
// it is taken. Reset clears the kept count, the reference point and all
// channel state; the block is ready the cycle after reset falls.
`default_nettype none

module k_nearest_point_selector (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [knps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [knps_pkg::COORD_W-1:0]      cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  signed [knps_pkg::COORD_W-1:0] point_x,
  input  wire  signed [knps_pkg::COORD_W-1:0] point_y,
  input  wire                               alive,
  input  wire                               end_of_set,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              found,
  output logic [knps_pkg::RANK_W-1:0]       rank,
  output logic signed [knps_pkg::COORD_W-1:0] near_x,
  output logic signed [knps_pkg::COORD_W-1:0] near_y,
  output logic [knps_pkg::ROOT_W-1:0]       distance,
  output logic                              last_of_run
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int N  = knps_pkg::MAX_KEPT;
  localparam int IW = knps_pkg::IDX_W;
  localparam int CW = knps_pkg::CNT_W;

  logic [2:0]             state;
  logic [2:0]             state_next;
  knps_pkg::coord_t       ref_x;
  knps_pkg::coord_t       ref_y;
  knps_pkg::coord_t       px;
  knps_pkg::coord_t       py;
  logic                   eos;
  knps_pkg::sq_t          sq;
  logic [CW-1:0]          kept_count;
  logic [CW-1:0]          w;
  logic [IW-1:0]          k;
  knps_pkg::coord_t       kept_x [N];
  knps_pkg::coord_t       kept_y [N];
  knps_pkg::sq_t          kept_sq_dist [N];

  knps_pkg::unit_req_t    dist_req;
  knps_pkg::unit_stat_t   dist_stat;
  knps_pkg::sq_t          dist_sq;
  knps_pkg::unit_req_t    sqrt_req;
  knps_pkg::unit_stat_t   sqrt_stat;
  knps_pkg::root_t        sqrt_root;

  logic                   accept;
  logic [IW-1:0]          w_idx;
  logic [IW-1:0]          w_prev;
  logic                   w_in;
  logic                   move_up;
  logic                   ins_done;
  logic                   emit_go;
  logic                   emit_empty;
  logic                   kick;
  logic                   out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_take  = (state == S_OUT) && out_valid && !out_stall;

  // walk the list from the tail: entries farther than the new point move down
  always_comb begin
    w_idx      = IW'(w);
    w_prev     = IW'(w - CW'(1));
    w_in       = (w < CW'(N));
    move_up    = (w != '0) && (kept_sq_dist[w_prev] > sq);
    ins_done   = (state == S_INS) && !move_up;
    emit_go    = (accept && !alive && end_of_set) || (ins_done && eos);
    // a live end item always leaves at least one entry
    emit_empty = emit_go && !ins_done && (kept_count == '0);
  end

  // after a live end item the root starts once the insert has landed
  assign dist_req.start = accept && alive;
  assign sqrt_req.start = (emit_go && !ins_done && !emit_empty) || kick ||
                          (out_take && !last_of_run);

  knps_sqdist u_sqdist (
    .clk  (clk),
    .rst  (rst),
    .req  (dist_req),
    .px   (point_x),
    .py   (point_y),
    .rx   (ref_x),
    .ry   (ref_y),
    .stat (dist_stat),
    .sq   (dist_sq)
  );

  // the head entry is always the next one to report
  knps_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .req      (sqrt_req),
    .radicand (kept_sq_dist[0]),
    .stat     (sqrt_stat),
    .root_out (sqrt_root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && alive) begin
          state_next = S_DIST;
        end
      end
      S_DIST: if (dist_stat.done) state_next = S_INS;
      S_INS:  if (ins_done) state_next = S_IDLE;
      S_SQRT: if (sqrt_stat.done) state_next = S_OUT;
      S_OUT: begin
        if (out_take) begin
          state_next = last_of_run ? S_IDLE : S_SQRT;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (emit_go) begin
      state_next = emit_empty ? S_OUT : S_SQRT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ref_x      <= '0;
      ref_y      <= '0;
      kept_count <= '0;
      out_valid  <= 1'b0;
      kick       <= 1'b0;
    end else begin
      state <= state_next;
      kick  <= ins_done && eos;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          knps_pkg::REG_REF_X: ref_x <= cfg_data;
          knps_pkg::REG_REF_Y: ref_y <= cfg_data;
          default: ;
        endcase
      end
      if (ins_done && w_in && kept_count < CW'(N)) begin
        kept_count <= kept_count + CW'(1);
      end
      if (emit_empty) begin
        out_valid <= 1'b1;
      end else if (state == S_SQRT && sqrt_stat.done) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
        if (last_of_run) begin
          kept_count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px  <= point_x;
      py  <= point_y;
      eos <= end_of_set;
    end
    if (state == S_DIST && dist_stat.done) begin
      sq <= dist_sq;
      w  <= kept_count;
    end
    if (state == S_INS && w_in) begin
      if (move_up) begin
        kept_x[w_idx]       <= kept_x[w_prev];
        kept_y[w_idx]       <= kept_y[w_prev];
        kept_sq_dist[w_idx] <= kept_sq_dist[w_prev];
      end else begin
        kept_x[w_idx]       <= px;
        kept_y[w_idx]       <= py;
        kept_sq_dist[w_idx] <= sq;
      end
    end
    if (state == S_INS && move_up) begin
      w <= w - CW'(1);
    end

    if (emit_go) begin
      k <= '0;
      if (emit_empty) begin
        found       <= 1'b0;
        rank        <= '0;
        near_x      <= '0;
        near_y      <= '0;
        distance    <= '0;
        last_of_run <= 1'b1;
      end
    end else if (out_take) begin
      k <= k + IW'(1);
    end

    // load the head into the output register and pull the list up
    if (state == S_SQRT && sqrt_stat.done) begin
      found       <= 1'b1;
      rank        <= knps_pkg::RANK_W'(k);
      near_x      <= kept_x[0];
      near_y      <= kept_y[0];
      distance    <= sqrt_root;
      last_of_run <= (CW'(k) + CW'(1) == kept_count);
      for (int i = 0; i < N - 1; i++) begin
        kept_x[i]       <= kept_x[i + 1];
        kept_y[i]       <= kept_y[i + 1];
        kept_sq_dist[i] <= kept_sq_dist[i + 1];
      end
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result shown outside output state");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(N))
    else $error("kept count beyond list depth");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_of_run) |=> (kept_count == '0 && state == S_IDLE))
    else $error("list not cleared after last result");

  a_ready_not_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (!out_valid && !dist_stat.busy && !sqrt_stat.busy))
    else $error("ready while a unit is still working");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 424;
  localparam int PHASES         = 8;

  // indexes with no register behind them; writes must be ignored
  localparam logic [knps_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = knps_pkg::CFG_IDX_W'(2);
  localparam logic [knps_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = knps_pkg::CFG_IDX_W'(3);

  typedef struct {
    knps_pkg::coord_t x;
    knps_pkg::coord_t y;
    longint unsigned  sq;
  } kept_pt_t;

  typedef struct {
    logic                        found;
    logic [knps_pkg::RANK_W-1:0] rank;
    knps_pkg::coord_t            x;
    knps_pkg::coord_t            y;
    knps_pkg::root_t             root_v;
    logic                        last;
  } pick_t;

  class nearest_scoreboard;
    knps_pkg::coord_t ref_x;
    knps_pkg::coord_t ref_y;
    kept_pt_t         nearest[$];
    pick_t            due_picks[$];
    int               errors;

    function new();
      ref_x  = '0;
      ref_y  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [knps_pkg::CFG_IDX_W-1:0] idx, knps_pkg::coord_t data);
      if (idx == knps_pkg::REG_REF_X) begin
        ref_x = data;
      end else if (idx == knps_pkg::REG_REF_Y) begin
        ref_y = data;
      end
    endfunction

    // floor root by bisection, then round half up (no exact half for integers)
    function knps_pkg::root_t round_root(longint unsigned s);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 64'd131072;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (mid * mid <= s) lo = mid;
        else hi = mid;
      end
      if (s - lo * lo > lo) lo++;
      return knps_pkg::root_t'(lo);
    endfunction

    function void insert_candidate(knps_pkg::coord_t px, knps_pkg::coord_t py);
      longint   dx;
      longint   dy;
      kept_pt_t pt;
      int       pos;
      dx    = longint'(px) - longint'(ref_x);
      dy    = longint'(py) - longint'(ref_y);
      pt.x  = px;
      pt.y  = py;
      pt.sq = longint'(dx * dx + dy * dy);
      // ties go behind earlier arrivals
      pos = nearest.size();
      while (pos > 0 && nearest[pos-1].sq > pt.sq) pos--;
      nearest.insert(pos, pt);
      if (nearest.size() > knps_pkg::MAX_KEPT) void'(nearest.pop_back());
    endfunction

    function void note_request(knps_pkg::coord_t px, knps_pkg::coord_t py, logic live,
                               logic last);
      pick_t p;
      if (live) insert_candidate(px, py);
      if (!last) return;
      if (nearest.size() == 0) begin
        p.found  = 1'b0;
        p.rank   = '0;
        p.x      = '0;
        p.y      = '0;
        p.root_v = '0;
        p.last   = 1'b1;
        due_picks = {due_picks, p};
      end else begin
        foreach (nearest[k]) begin
          p.found  = 1'b1;
          p.rank   = knps_pkg::RANK_W'(k);
          p.x      = nearest[k].x;
          p.y      = nearest[k].y;
          p.root_v = round_root(nearest[k].sq);
          p.last   = (k == nearest.size() - 1);
          due_picks = {due_picks, p};
        end
      end
      nearest.delete();
    endfunction

    function void match(string field, longint want_v, longint got_v);
      if (want_v != got_v) begin
        $error("%s: expected %0d, got %0d", field, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic f, logic [knps_pkg::RANK_W-1:0] r,
                               knps_pkg::coord_t x, knps_pkg::coord_t y,
                               knps_pkg::root_t d, logic l);
      pick_t w;
      if (due_picks.size() == 0) begin
        $error("result with nothing outstanding: found=%0d rank=%0d", f, r);
        errors++;
        return;
      end
      w = due_picks.pop_front();
      match("found", w.found, f);
      match("rank", w.rank, r);
      match("near_x", w.x, x);
      match("near_y", w.y, y);
      match("distance", w.root_v, d);
      match("last_of_run", w.last, l);
    endfunction

    function int pending();
      return due_picks.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [knps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [knps_pkg::COORD_W-1:0]   cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  knps_pkg::coord_t               point_x;
  knps_pkg::coord_t               point_y;
  logic                           alive;
  logic                           end_of_set;
  logic                           out_valid;
  logic                           out_stall;
  logic                           found;
  logic [knps_pkg::RANK_W-1:0]    rank;
  knps_pkg::coord_t               near_x;
  knps_pkg::coord_t               near_y;
  knps_pkg::root_t                distance;
  logic                           last_of_run;

  nearest_scoreboard sb;
  knps_pkg::coord_t cur_ref_x;
  knps_pkg::coord_t cur_ref_y;
  int     items_sent;
  int     quiet_cycles = 0;
  int     tx_odds;
  int     rx_odds;
  bit     calm;
  bit     hold_req;
  bit     hold_taken;

  k_nearest_point_selector u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .alive       (alive),
    .end_of_set  (end_of_set),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .rank        (rank),
    .near_x      (near_x),
    .near_y      (near_y),
    .distance    (distance),
    .last_of_run (last_of_run)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(point_x, point_y, alive, end_of_set);
      if (out_valid && !out_stall) begin
        sb.check_result(found, rank, near_x, near_y, distance, last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side pacing; one long hold-off to back the block up
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, rx_odds) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(input logic [knps_pkg::CFG_IDX_W-1:0] idx,
                           input knps_pkg::coord_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_ref(input knps_pkg::coord_t x, input knps_pkg::coord_t y);
    cfg_write(knps_pkg::REG_REF_X, x);
    cfg_write(knps_pkg::REG_REF_Y, y);
    cfg_valid <= 1'b0;
    cur_ref_x = x;
    cur_ref_y = y;
  endtask

  task automatic send_point(input knps_pkg::coord_t px, input knps_pkg::coord_t py,
                            input logic live, input logic last);
    if (!calm && $urandom_range(0, tx_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    point_x    <= px;
    point_y    <= py;
    alive      <= live;
    end_of_set <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait for every result, then a margin for work that yields none
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic knps_pkg::coord_t pick_ref();
    case ($urandom_range(0, 4))
      0: return knps_pkg::coord_t'(16'h8000);
      1: return knps_pkg::coord_t'(16'h7fff);
      2: return '0;
      default: return knps_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic send_random_set();
    int               n;
    int               style;
    int               k;
    int               sel;
    knps_pkg::coord_t px;
    knps_pkg::coord_t py;
    logic             live;
    knps_pkg::coord_t pool_x[3];
    knps_pkg::coord_t pool_y[3];
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    style = $urandom_range(0, 3);
    for (k = 0; k < 3; k++) begin
      pool_x[k] = knps_pkg::coord_t'($urandom);
      pool_y[k] = knps_pkg::coord_t'($urandom);
    end
    for (k = 0; k <= n; k++) begin
      case (style)
        1: begin
          // around the reference: small distances, many ties
          px = cur_ref_x + knps_pkg::coord_t'($urandom_range(0, 16)) - knps_pkg::coord_t'(8);
          py = cur_ref_y + knps_pkg::coord_t'($urandom_range(0, 16)) - knps_pkg::coord_t'(8);
        end
        2: begin
          sel = $urandom_range(0, 2);
          px  = pool_x[sel];
          py  = pool_y[sel];
        end
        default: begin
          px = knps_pkg::coord_t'($urandom);
          py = knps_pkg::coord_t'($urandom);
        end
      endcase
      // style 3 is mostly dead noise
      live = (style == 3) ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 7) != 0);
      send_point(px, py, live, k == n);
    end
  endtask

  initial begin
    int ph;
    int start_items;
    sb = new();
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    point_x    <= '0;
    point_y    <= '0;
    alive      <= 1'b0;
    end_of_set <= 1'b0;
    cur_ref_x  = '0;
    cur_ref_y  = '0;
    items_sent = 0;
    tx_odds    = 4;
    rx_odds    = 4;
    calm       = 1'b0;
    hold_req   = 1'b0;
    hold_taken = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reference at its reset value: empty sets, lone far point, ties, overflow
    send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_point(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b0, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    send_point(16'sd3, 16'sd4, 1'b1, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1, 1'b0);
    send_point(16'sd4, 16'sd3, 1'b1, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
    send_point(-16'sd5, 16'sd0, 1'b1, 1'b0);
    send_point(16'sd1, -16'sd1, 1'b1, 1'b0);
    send_point(16'sd6, 16'sd8, 1'b1, 1'b0);
    send_point(16'sd0, 16'sd5, 1'b1, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
    send_point(16'sd7, 16'sd24, 1'b1, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0, 1'b0);
    send_point(16'sd0, -16'sd5, 1'b1, 1'b1);
    drain();

    // spare indexes must not disturb the reference
    cfg_write(REG_UNUSED_A, knps_pkg::coord_t'(16'h1234));
    cfg_write(REG_UNUSED_B, knps_pkg::coord_t'(16'hffff));
    set_ref(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
    drain();

    set_ref(16'sh7fff, 16'sh7fff);
    send_point(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
    send_point(16'sh7ffe, 16'sh7ffe, 1'b1, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      set_ref(pick_ref(), pick_ref());
      tx_odds = ($urandom_range(0, 2) == 0) ? 1000 : $urandom_range(1, 6);
      rx_odds = ($urandom_range(0, 2) == 0) ? 1000 : $urandom_range(1, 6);
      if (ph == 2) hold_req = 1'b1;
      if (ph == PHASES - 1) calm = 1'b1;
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS / PHASES) send_random_set();
      drain();
    end

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
